[src/wsfr_pkg.sv]
// Package for the frame receiver: phase encoding, result kinds, error codes.
// No dependencies.
package wsfr_pkg;

  localparam int LENGTH_BITS_DEF = 64;
  localparam logic [31:0] MAX_BODY_RST = 32'd1048576;
  localparam logic [6:0] LEN_16 = 7'd126;
  localparam logic [6:0] LEN_64 = 7'd127;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PONG = 4'hA;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_BODY = 3'd3,
    PH_ERR  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_FRAG = 2'd1,
    ERR_RSV  = 2'd2,
    ERR_BIG  = 2'd3
  } err_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       last;
    logic       needs_response;
    logic       close_after;
    logic [1:0] error_kind;
  } result_t;

  function automatic logic needs_resp(input logic [3:0] op);
    return (op > 4'd7) && (op != OP_PONG);
  endfunction

endpackage

[src/websocket_frame_receiver.sv]
// Frame receiver top level: parser front, two-entry result queue back.
// Results are registered into the queue and reach the out_ ports from its head.
// Throughput: one byte per cycle unless full, i.e. two results wait unpopped.
// Reset: rst_n synchronous, active low; returns to awaiting a first header byte,
// clears the error lock and sets max_body_length to 1048576.
module websocket_frame_receiver import wsfr_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [3:0]  out_frame_opcode,
  output logic        out_last,
  output logic        out_needs_response,
  output logic        out_close_after,
  output logic [1:0]  out_error_kind,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] max_len_r;
  logic        beat, res_valid, rd;
  result_t     res, head;

  assign beat = push && !full;
  assign rd = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) max_len_r <= MAX_BODY_RST;
    else if (cfg_we) max_len_r <= cfg_wdata;
  end

  wsfr_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
    .clk(clk), .rst_n(rst_n), .beat_i(beat), .byte_i(in_rx_byte),
    .max_len_i(max_len_r), .res_valid_o(res_valid), .res_o(res)
  );

  wsfr_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_i(res_valid), .wdata_i(res),
    .rd_i(rd), .rdata_o(head), .empty_o(empty), .full_o(full)
  );

  assign out_kind = head.kind;
  assign out_payload_byte = head.payload_byte;
  assign out_frame_opcode = head.frame_opcode;
  assign out_last = head.last;
  assign out_needs_response = head.needs_response;
  assign out_close_after = head.close_after;
  assign out_error_kind = head.error_kind;

  a_err_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_ERROR) |-> out_needs_response && !out_last)
    else $error("error result without response flag");
  a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != KIND_ERROR) |-> out_error_kind == ERR_NONE)
    else $error("error code on non-error result");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |=> !empty)
    else $error("queue drained while full");

endmodule

[src/wsfr_parser.sv]
// Front part: header parser and unmasker, one byte per cycle while beat_i is high.
// Depends on wsfr_pkg.
module wsfr_parser import wsfr_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        beat_i,
  input  logic [7:0]  byte_i,
  input  logic [31:0] max_len_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             op_r, op_nxt;
  logic                   mask_r, mask_nxt;
  logic [6:0]             slen_r, slen_nxt;
  logic [LENGTH_BITS-1:0] plen_r, plen_nxt;
  logic [3:0]             hcnt_r, hcnt_nxt;
  logic [7:0]             key_r [4];
  logic                   key_we;
  logic [1:0]             key_idx;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [1:0]             midx_r, midx_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [3:0]             lbytes, need;
  logic [3:0]             hcnt_inc;
  logic [3:0]             h1_lb;
  logic                   fin;
  logic                   too_big;
  logic [LENGTH_BITS-1:0] fin_len;
  logic                   fin_ovf;
  logic [LENGTH_BITS-1:0] rem_dec;

  always_comb begin
    lbytes = (slen_r == LEN_16) ? 4'd2 : (slen_r == LEN_64) ? 4'd8 : 4'd0;
    h1_lb = (byte_i[6:0] == LEN_16) ? 4'd2 : (byte_i[6:0] == LEN_64) ? 4'd8 : 4'd0;
    need = lbytes + (mask_r ? 4'd4 : 4'd0);
    hcnt_inc = hcnt_r + 4'd1;
    rem_dec = (rem_r != '0) ? rem_r - 1'b1 : rem_r;
  end

  always_comb begin
    phase_nxt = phase_r;
    op_nxt = op_r;
    mask_nxt = mask_r;
    slen_nxt = slen_r;
    plen_nxt = plen_r;
    hcnt_nxt = hcnt_r;
    rem_nxt = rem_r;
    midx_nxt = midx_r;
    ovf_nxt = ovf_r;
    key_we = 1'b0;
    key_idx = 2'(hcnt_r - lbytes);
    fin = 1'b0;
    fin_len = plen_r;
    fin_ovf = ovf_r;
    res_valid_o = 1'b0;
    res_o = '0;
    if (beat_i) begin
      unique case (phase_r)
        PH_HDR0: begin
          res_o.frame_opcode = byte_i[3:0];
          res_o.needs_response = 1'b1;
          res_o.close_after = (byte_i[3:0] == OP_CLOSE);
          res_o.kind = KIND_ERROR;
          if (!byte_i[7]) begin
            res_valid_o = 1'b1;
            res_o.error_kind = ERR_FRAG;
            phase_nxt = PH_ERR;
          end else if (byte_i[6:4] != 3'd0) begin
            res_valid_o = 1'b1;
            res_o.error_kind = ERR_RSV;
            phase_nxt = PH_ERR;
          end else begin
            op_nxt = byte_i[3:0];
            phase_nxt = PH_HDR1;
          end
        end
        PH_HDR1: begin
          mask_nxt = byte_i[7];
          slen_nxt = byte_i[6:0];
          hcnt_nxt = '0;
          ovf_nxt = 1'b0;
          plen_nxt = (byte_i[6:0] < LEN_16) ? LENGTH_BITS'(byte_i[6:0]) : '0;
          fin_len = plen_nxt;
          fin_ovf = 1'b0;
          if (h1_lb == 4'd0 && !byte_i[7]) fin = 1'b1;
          else phase_nxt = PH_EXT;
        end
        PH_EXT: begin
          if (hcnt_r < lbytes) begin
            if (plen_r[LENGTH_BITS-1 -: 8] != 8'd0) ovf_nxt = 1'b1;
            plen_nxt = {plen_r[LENGTH_BITS-9:0], byte_i};
          end else begin
            key_we = 1'b1;
          end
          hcnt_nxt = hcnt_inc;
          fin_len = plen_nxt;
          fin_ovf = ovf_nxt;
          if (hcnt_inc >= need) fin = 1'b1;
        end
        PH_BODY: begin
          res_valid_o = 1'b1;
          res_o.kind = KIND_PAYLOAD;
          res_o.payload_byte = mask_r ? (byte_i ^ key_r[midx_r]) : byte_i;
          res_o.frame_opcode = op_r;
          res_o.last = (rem_dec == '0);
          res_o.needs_response = needs_resp(op_r);
          res_o.close_after = (op_r == OP_CLOSE);
          midx_nxt = midx_r + 2'd1;
          rem_nxt = rem_dec;
          if (rem_dec == '0) phase_nxt = PH_HDR0;
        end
        default: phase_nxt = PH_ERR;
      endcase
    end
    too_big = fin_ovf || (64'(fin_len) > 64'(max_len_i));
    if (fin) begin
      res_valid_o = 1'b1;
      res_o.frame_opcode = op_r;
      res_o.close_after = (op_r == OP_CLOSE);
      if (too_big) begin
        res_o.kind = KIND_ERROR;
        res_o.needs_response = 1'b1;
        res_o.error_kind = ERR_BIG;
        phase_nxt = PH_ERR;
      end else begin
        res_o.kind = KIND_HEADER;
        res_o.last = (fin_len == '0);
        res_o.needs_response = needs_resp(op_r);
        rem_nxt = fin_len;
        midx_nxt = 2'd0;
        phase_nxt = (fin_len == '0) ? PH_HDR0 : PH_BODY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      op_r <= '0;
      mask_r <= 1'b0;
      slen_r <= '0;
      plen_r <= '0;
      hcnt_r <= '0;
      rem_r <= '0;
      midx_r <= '0;
      ovf_r <= 1'b0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else begin
      phase_r <= phase_nxt;
      op_r <= op_nxt;
      mask_r <= mask_nxt;
      slen_r <= slen_nxt;
      plen_r <= plen_nxt;
      hcnt_r <= hcnt_nxt;
      rem_r <= rem_nxt;
      midx_r <= midx_nxt;
      ovf_r <= ovf_nxt;
      if (key_we) key_r[key_idx] <= byte_i;
    end
  end

endmodule

[src/wsfr_queue.sv]
// Back part: short result queue between parser and output handshake.
// Depends on wsfr_pkg.
module wsfr_queue import wsfr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_i,
  input  result_t wdata_i,
  input  logic    rd_i,
  output result_t rdata_o,
  output logic    empty_o,
  output logic    full_o
);

  result_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty_o = (cnt_r == 2'd0);
  assign full_o = (cnt_r == 2'd2);
  assign rdata_o = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_i) mem_r[wp_r] <= wdata_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_i) wp_r <= ~wp_r;
      if (rd_i) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_i) - 2'(rd_i);
    end
  end

endmodule
